FILE: rtl/vpw_bus_receiver_macros.svh
// ----------------------------------------------------------------------------
// VPW bus receiver assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef VPW_BUS_RECEIVER_MACROS_SVH
`define VPW_BUS_RECEIVER_MACROS_SVH

// Condition holds at every edge outside reset.
`define VPW_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define VPW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/vpw_pkg.sv
// ----------------------------------------------------------------------------
// VPW receiver package
// Result kinds, register indexes, register reset values and the width
// window compare shared by the receiver modules.
// ----------------------------------------------------------------------------
package vpw_pkg;

  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOF_WIDTH   = 3'd0,
    REG_SOF_TOL     = 3'd1,
    REG_SHORT_WIDTH = 3'd2,
    REG_SHORT_TOL   = 3'd3,
    REG_LONG_WIDTH  = 3'd4,
    REG_LONG_TOL    = 3'd5
  } reg_index_t;

  localparam logic [WIDTH_W-1:0] SOF_WIDTH_RST   = 16'd300;
  localparam logic [WIDTH_W-1:0] SOF_TOL_RST     = 16'd45;
  localparam logic [WIDTH_W-1:0] SHORT_WIDTH_RST = 16'd96;
  localparam logic [WIDTH_W-1:0] SHORT_TOL_RST   = 16'd30;
  localparam logic [WIDTH_W-1:0] LONG_WIDTH_RST  = 16'd192;
  localparam logic [WIDTH_W-1:0] LONG_TOL_RST    = 16'd30;

  typedef struct packed {
    logic [WIDTH_W-1:0] sof_width;
    logic [WIDTH_W-1:0] sof_tolerance;
    logic [WIDTH_W-1:0] short_width;
    logic [WIDTH_W-1:0] short_tolerance;
    logic [WIDTH_W-1:0] long_width;
    logic [WIDTH_W-1:0] long_tolerance;
  } cfg_t;

  typedef struct packed {
    logic sof_hit;
    logic short_hit;
    logic long_hit;
  } match_t;

  // Width lies strictly inside the tolerance window around nominal.
  function automatic logic near_width(input logic [WIDTH_W-1:0] w,
                                      input logic [WIDTH_W-1:0] nominal,
                                      input logic [WIDTH_W-1:0] tol);
    logic [WIDTH_W-1:0] diff;
    diff = (w >= nominal) ? (w - nominal) : (nominal - w);
    return diff < tol;
  endfunction

endpackage

FILE: rtl/vpw_symbol_class.sv
// ----------------------------------------------------------------------------
// VPW symbol classifier
// Compares one pulse width against the start-of-frame, short and long
// windows.
// ----------------------------------------------------------------------------
module vpw_symbol_class (
  input  logic [vpw_pkg::WIDTH_W-1:0] pulse_width,
  input  vpw_pkg::cfg_t               cfg,
  output vpw_pkg::match_t             hits
);

  assign hits.sof_hit   = vpw_pkg::near_width(pulse_width, cfg.sof_width,
                                              cfg.sof_tolerance);
  assign hits.short_hit = vpw_pkg::near_width(pulse_width, cfg.short_width,
                                              cfg.short_tolerance);
  assign hits.long_hit  = vpw_pkg::near_width(pulse_width, cfg.long_width,
                                              cfg.long_tolerance);

endmodule

FILE: rtl/vpw_bus_receiver.sv
// Path: an accepted beat is captured in the input register and decoded into
// the result register, from which its result beat is offered.
// Throughput: one beat per cycle while out_stall is low; the result register
// and the input register together let a beat in while a result waits.
// Reset: synchronous rst clears control state and reloads register defaults.
// ----------------------------------------------------------------------------
// VPW bus receiver
// Decodes variable pulse width bus events into frame start, data byte,
// symbol error and frame end results. Transmit and CRC are not included.
// ----------------------------------------------------------------------------
module vpw_bus_receiver #(
  parameter int unsigned FRAME_BYTES_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // event input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] pulse_width,
  input  logic        line_level,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [4:0]  byte_count,
  output logic        overflow
);

  // Frame byte counter holds 0 .. FRAME_BYTES_MAX.
  localparam int unsigned CNT_W = $clog2(FRAME_BYTES_MAX + 1);

  // --------------------------------------------------------------------------
  // Configuration registers: always ready, out-of-range indexes dropped.
  // --------------------------------------------------------------------------
  vpw_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sof_width       <= vpw_pkg::SOF_WIDTH_RST;
      cfg.sof_tolerance   <= vpw_pkg::SOF_TOL_RST;
      cfg.short_width     <= vpw_pkg::SHORT_WIDTH_RST;
      cfg.short_tolerance <= vpw_pkg::SHORT_TOL_RST;
      cfg.long_width      <= vpw_pkg::LONG_WIDTH_RST;
      cfg.long_tolerance  <= vpw_pkg::LONG_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vpw_pkg::REG_SOF_WIDTH:   cfg.sof_width       <= cfg_data;
        vpw_pkg::REG_SOF_TOL:     cfg.sof_tolerance   <= cfg_data;
        vpw_pkg::REG_SHORT_WIDTH: cfg.short_width     <= cfg_data;
        vpw_pkg::REG_SHORT_TOL:   cfg.short_tolerance <= cfg_data;
        vpw_pkg::REG_LONG_WIDTH:  cfg.long_width      <= cfg_data;
        vpw_pkg::REG_LONG_TOL:    cfg.long_tolerance  <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. It advances whenever the result register can take a new
  // value, i.e. it is empty or its beat leaves this cycle.
  // --------------------------------------------------------------------------
  logic        s1_valid;
  logic        s1_func;
  logic [15:0] s1_width;
  logic        s1_level;
  logic        adv;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Hold payload while stalled; load only on an accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func  <= func;
      s1_width <= pulse_width;
      s1_level <= line_level;
    end
  end

  // --------------------------------------------------------------------------
  // Width windows
  // --------------------------------------------------------------------------
  vpw_pkg::match_t hits;

  vpw_symbol_class u_class (
    .pulse_width (s1_width),
    .cfg         (cfg),
    .hits        (hits)
  );

  // --------------------------------------------------------------------------
  // Frame state and result decode
  // --------------------------------------------------------------------------
  logic             receiving;
  logic [2:0]       bit_count;
  logic [7:0]       shift_byte;
  logic [CNT_W-1:0] frame_bytes;

  logic             receiving_next;
  logic [2:0]       bit_count_next;
  logic [7:0]       shift_byte_next;
  logic [CNT_W-1:0] frame_bytes_next;

  logic             res_valid;
  vpw_pkg::kind_t   res_kind;
  logic [7:0]       res_data;
  logic [4:0]       res_count;
  logic             res_ovf;

  logic             sym_ok;
  logic             sym_bit;
  logic [7:0]       shifted;
  logic [CNT_W-1:0] bytes_inc;

  always_comb begin
    // Short window wins when a width falls in both.
    sym_ok  = hits.short_hit || hits.long_hit;
    sym_bit = hits.short_hit ? !s1_level : s1_level;
    shifted = {shift_byte[6:0], sym_bit};
    bytes_inc = frame_bytes + CNT_W'(1);

    receiving_next   = receiving;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    frame_bytes_next = frame_bytes;
    res_valid = 1'b0;
    res_kind  = vpw_pkg::KIND_START;
    res_data  = '0;
    res_count = '0;
    res_ovf   = 1'b0;

    if (s1_valid && adv) begin
      if (s1_func) begin
        // Timeout: report the end of an open frame, drop any partial byte.
        if (receiving) begin
          receiving_next   = 1'b0;
          frame_bytes_next = '0;
          res_valid = 1'b1;
          res_kind  = vpw_pkg::KIND_END;
          res_count = 5'(frame_bytes);
        end
      end else if (!receiving) begin
        // Idle: only a start-of-frame pulse ending low opens a frame.
        if (!s1_level && hits.sof_hit) begin
          receiving_next   = 1'b1;
          bit_count_next   = '0;
          shift_byte_next  = '0;
          frame_bytes_next = '0;
          res_valid = 1'b1;
          res_kind  = vpw_pkg::KIND_START;
        end
      end else if (!sym_ok) begin
        // Unmatched width: abort the frame.
        receiving_next = 1'b0;
        res_valid = 1'b1;
        res_kind  = vpw_pkg::KIND_ERROR;
        res_count = 5'(frame_bytes);
      end else begin
        shift_byte_next = shifted;
        bit_count_next  = bit_count + 3'd1;
        if (bit_count == 3'd7) begin
          // Eighth bit: emit the byte; a full buffer closes the frame.
          frame_bytes_next = bytes_inc;
          res_valid = 1'b1;
          res_kind  = vpw_pkg::KIND_BYTE;
          res_data  = shifted;
          res_count = 5'(bytes_inc);
          if (bytes_inc >= CNT_W'(FRAME_BYTES_MAX)) begin
            res_ovf        = 1'b1;
            receiving_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving   <= 1'b0;
      bit_count   <= '0;
      shift_byte  <= '0;
      frame_bytes <= '0;
    end else begin
      receiving   <= receiving_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      frame_bytes <= frame_bytes_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: load on advance, drop the beat once taken.
  // --------------------------------------------------------------------------
  vpw_pkg::kind_t out_kind;
  logic [7:0]     out_data;
  logic [4:0]     out_count;
  logic           out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_kind  <= res_kind;
      out_data  <= res_data;
      out_count <= res_count;
      out_ovf   <= res_ovf;
    end
  end

  assign kind       = out_kind;
  assign data_byte  = out_data;
  assign byte_count = out_count;
  assign overflow   = out_ovf;

endmodule

FILE: rtl/vpw_checker.sv
// ----------------------------------------------------------------------------
// VPW receiver port checker
// Watches the receiver's ports and flags result beats or flow control that
// the receiver can never produce.
// ----------------------------------------------------------------------------
`include "vpw_bus_receiver_macros.svh"

module vpw_checker #(
  parameter int unsigned FRAME_BYTES_MAX = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [7:0]  data_byte,
  input logic [4:0]  byte_count,
  input logic        overflow
);

  // A stalled result beat holds.
  `VPW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({kind, data_byte, byte_count, overflow}), "stalled result beat changed")

  // Frame start carries no byte, no count and no overflow.
  `VPW_ASSERT_ALWAYS(a_start_clean, !(out_valid && kind == vpw_pkg::KIND_START) || (data_byte == 8'd0 && byte_count == 5'd0 && !overflow), "frame start with payload")

  // Overflow only on the data byte that fills the buffer.
  `VPW_ASSERT_ALWAYS(a_ovf_byte, !(out_valid && overflow) || (kind == vpw_pkg::KIND_BYTE && byte_count == 5'(FRAME_BYTES_MAX)), "overflow on wrong beat")

  // Input never stalls while the result register is empty.
  `VPW_ASSERT_ALWAYS(a_no_idle_stall, out_valid || !in_stall, "input stalled with empty result register")

endmodule

bind vpw_bus_receiver vpw_checker #(.FRAME_BYTES_MAX(FRAME_BYTES_MAX)) u_vpw_checker (.*);

FILE: sim/vpw_bus_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// VPW bus receiver testbench
// Drives bus edge and timeout beats through the receiver under several
// timing settings, predicts frame start, data byte, symbol error and frame
// end results with a scoreboard, and checks every result beat in order.
// ----------------------------------------------------------------------------
module vpw_bus_receiver_tb;

  localparam int unsigned FRAME_LIMIT   = 16;
  // Settling wait after the last owed result, to let the input and result registers empty.
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct {
    vpw_pkg::kind_t kind;
    logic [7:0]     data;
    logic [4:0]     count;
    logic           full;
  } vpw_result_t;

  typedef enum {CLOSE_TIMEOUT, CLOSE_SYMBOL_ERR, CLOSE_NONE} frame_close_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks decoder state and the queue of results still owed.
  // --------------------------------------------------------------------------
  class vpw_decode_sb;
    logic [15:0]   sof_w, sof_tol, short_w, short_tol, long_w, long_tol;
    bit            in_frame;
    int unsigned   bits_held;
    logic [7:0]    shift_acc;
    int unsigned   bytes_in_frame;
    int unsigned   frame_limit;
    vpw_result_t   expected_results[$];
    int            mismatches;

    function new(int unsigned limit);
      frame_limit    = limit;
      sof_w          = vpw_pkg::SOF_WIDTH_RST;
      sof_tol        = vpw_pkg::SOF_TOL_RST;
      short_w        = vpw_pkg::SHORT_WIDTH_RST;
      short_tol      = vpw_pkg::SHORT_TOL_RST;
      long_w         = vpw_pkg::LONG_WIDTH_RST;
      long_tol       = vpw_pkg::LONG_TOL_RST;
      in_frame       = 1'b0;
      bits_held      = 0;
      shift_acc      = 8'h00;
      bytes_in_frame = 0;
      mismatches     = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR @%0t: %s", $time, msg);
      end
    endfunction

    function void set_reg(vpw_pkg::reg_index_t idx, logic [15:0] v);
      case (idx)
        vpw_pkg::REG_SOF_WIDTH:   sof_w     = v;
        vpw_pkg::REG_SOF_TOL:     sof_tol   = v;
        vpw_pkg::REG_SHORT_WIDTH: short_w   = v;
        vpw_pkg::REG_SHORT_TOL:   short_tol = v;
        vpw_pkg::REG_LONG_WIDTH:  long_w    = v;
        vpw_pkg::REG_LONG_TOL:    long_tol  = v;
        default: ;
      endcase
    endfunction

    // Strict window: distance to nominal must stay below the tolerance.
    function bit in_window(logic [15:0] w, logic [15:0] nom, logic [15:0] tol);
      int delta;
      delta = int'(w) - int'(nom);
      if (delta < 0) delta = -delta;
      return delta < int'(tol);
    endfunction

    // Advance the decoder by one accepted beat and queue any result it owes.
    function void note_event(bit f, logic [15:0] w, bit lvl);
      vpw_result_t r;
      bit          b;
      if (f) begin
        // timeout: close an open frame, ignore otherwise
        if (!in_frame) return;
        r = '{kind: vpw_pkg::KIND_END, data: 8'h00, count: 5'(bytes_in_frame),
              full: 1'b0};
        in_frame       = 1'b0;
        bytes_in_frame = 0;
        expected_results.push_back(r);
        return;
      end
      if (!in_frame) begin
        if (!lvl && in_window(w, sof_w, sof_tol)) begin
          in_frame       = 1'b1;
          bits_held      = 0;
          shift_acc      = 8'h00;
          bytes_in_frame = 0;
          r = '{kind: vpw_pkg::KIND_START, data: 8'h00, count: 5'd0, full: 1'b0};
          expected_results.push_back(r);
        end
        return;
      end
      // short wins when a width falls in both windows
      if (in_window(w, short_w, short_tol)) begin
        b = !lvl;
      end else if (in_window(w, long_w, long_tol)) begin
        b = lvl;
      end else begin
        in_frame = 1'b0;
        r = '{kind: vpw_pkg::KIND_ERROR, data: 8'h00, count: 5'(bytes_in_frame),
              full: 1'b0};
        expected_results.push_back(r);
        return;
      end
      shift_acc = {shift_acc[6:0], b};
      bits_held++;
      if (bits_held == 8) begin
        bits_held = 0;
        bytes_in_frame++;
        r = '{kind: vpw_pkg::KIND_BYTE, data: shift_acc, count: 5'(bytes_in_frame),
              full: (bytes_in_frame >= frame_limit)};
        if (r.full) in_frame = 1'b0;
        expected_results.push_back(r);
      end
    endfunction

    function void check_result(vpw_result_t got);
      vpw_result_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result kind=%0d byte=%02h count=%0d ovf=%0b",
                       got.kind, got.data, got.count, got.full));
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.count !== want.count || got.full !== want.full) begin
        flag($sformatf({"result mismatch: expected kind=%0d byte=%02h count=%0d ovf=%0b,",
                        " got kind=%0d byte=%02h count=%0d ovf=%0b"},
                       want.kind, want.data, want.count, want.full,
                       got.kind, got.data, got.count, got.full));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid;
  logic                cfg_ready;
  vpw_pkg::reg_index_t cfg_index;
  logic [15:0]         cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [15:0]         pulse_width;
  logic                line_level;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          kind;
  logic [7:0]          data_byte;
  logic [4:0]          byte_count;
  logic                overflow;

  vpw_decode_sb sb;
  int           beats_sent;
  bit           quiet;       // when set, neither side inserts gaps or stalls

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vpw_bus_receiver #(
    .FRAME_BYTES_MAX (FRAME_LIMIT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .pulse_width (pulse_width),
    .line_level  (line_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data_byte   (data_byte),
    .byte_count  (byte_count),
    .overflow    (overflow)
  );

  // --------------------------------------------------------------------------
  // Result side: random stall, sampled and checked at the rising edge.
  // --------------------------------------------------------------------------
  initial begin : stall_gen
    int r;
    int stall_hold;
    stall_hold = 0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
      end else if (quiet) begin
        out_stall = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          // accept freely for a while
          out_stall  = 1'b0;
          stall_hold = $urandom_range(0, 6);
        end else if (r < 90) begin
          out_stall  = 1'b1;
          stall_hold = $urandom_range(0, 2);
        end else begin
          // long back-pressure stretch
          out_stall  = 1'b1;
          stall_hold = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result('{kind: vpw_pkg::kind_t'(kind), data: data_byte,
                        count: byte_count, full: overflow});
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one, none while quiet.
  function automatic int gap_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pick a width inside the strict window, leaning on its outer edge.
  // With a zero tolerance nothing can match, so return any width.
  function automatic logic [15:0] pick_near(logic [15:0] nom, logic [15:0] tol);
    int off;
    int hi_v;
    int lo_v;
    if (tol == 16'd0) return 16'($urandom_range(0, 65535));
    off  = ($urandom_range(0, 3) == 0) ? int'(tol) - 1 : $urandom_range(0, int'(tol) - 1);
    hi_v = int'(nom) + off;
    lo_v = int'(nom) - off;
    if ($urandom_range(0, 1)) begin
      if (hi_v <= 65535) return 16'(hi_v);
      if (lo_v >= 0) return 16'(lo_v);
    end else begin
      if (lo_v >= 0) return 16'(lo_v);
      if (hi_v <= 65535) return 16'(hi_v);
    end
    return nom;
  endfunction

  // Present one beat after an optional gap and hold it until accepted.
  task automatic send_event(bit f, logic [15:0] w, bit lvl);
    int gap;
    gap = gap_cycles();
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    func        = f;
    pulse_width = w;
    line_level  = lvl;
    do @(posedge clk); while (in_stall);
    sb.note_event(f, w, lvl);
    beats_sent++;
  endtask

  // Drop valid, wait until every owed result is out, then let the pipe empty.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(vpw_pkg::reg_index_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_timing(logic [15:0] sof, logic [15:0] sof_tol,
                                logic [15:0] sh, logic [15:0] sh_tol,
                                logic [15:0] lg, logic [15:0] lg_tol);
    write_reg(vpw_pkg::REG_SOF_WIDTH, sof);
    write_reg(vpw_pkg::REG_SOF_TOL, sof_tol);
    write_reg(vpw_pkg::REG_SHORT_WIDTH, sh);
    write_reg(vpw_pkg::REG_SHORT_TOL, sh_tol);
    write_reg(vpw_pkg::REG_LONG_WIDTH, lg);
    write_reg(vpw_pkg::REG_LONG_TOL, lg_tol);
  endtask

  // Start of frame, random symbols, then the chosen way of closing the frame.
  task automatic send_frame(int nbytes, int extra_bits, frame_close_t close);
    int          nbits;
    bit          b;
    bit          use_short;
    logic [15:0] w;
    send_event(1'b0, pick_near(sb.sof_w, sb.sof_tol), 1'b0);
    nbits = nbytes * 8 + extra_bits;
    for (int i = 0; i < nbits; i++) begin
      b = 1'($urandom_range(0, 1));
      // steer away from a symbol class that cannot match at all
      if (sb.long_tol == 16'd0) use_short = 1'b1;
      else if (sb.short_tol == 16'd0) use_short = 1'b0;
      else use_short = 1'($urandom_range(0, 1));
      w = use_short ? pick_near(sb.short_w, sb.short_tol)
                    : pick_near(sb.long_w, sb.long_tol);
      send_event(1'b0, w, use_short ? !b : b);
    end
    case (close)
      CLOSE_TIMEOUT:    send_event(1'b1, 16'($urandom_range(0, 65535)),
                                   1'($urandom_range(0, 1)));
      CLOSE_SYMBOL_ERR: send_event(1'b0, 16'($urandom_range(0, 65535)),
                                   1'($urandom_range(0, 1)));
      default: ;
    endcase
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise.
  task automatic random_traffic(int budget);
    int           stop;
    int           r;
    int           nbytes;
    frame_close_t close;
    stop = beats_sent + budget;
    while (beats_sent < stop) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 75) close = CLOSE_TIMEOUT;
        else if (r < 92) close = CLOSE_SYMBOL_ERR;
        else close = CLOSE_NONE;
        send_frame(nbytes, $urandom_range(0, 7), close);
      end else if (r < 96) begin
        // noise beat: any function, width and level
        send_event($urandom_range(0, 3) == 0, 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
      end else begin
        // hold off the sender until the result side has caught up
        drain_results();
      end
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_valid   = 1'b0;
    cfg_index   = vpw_pkg::REG_SOF_WIDTH;
    cfg_data    = 16'h0000;
    in_valid    = 1'b0;
    func        = 1'b0;
    pulse_width = 16'h0000;
    line_level  = 1'b0;
    out_stall   = 1'b0;
    quiet       = 1'b0;
    beats_sent  = 0;
    sb          = new(FRAME_LIMIT);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed beats at the reset timing: sof 300+-45, short 96+-30, long 192+-30.
    send_event(1'b1, 16'd0, 1'b0);       // timeout while idle: ignored
    send_event(1'b0, 16'd0, 1'b0);       // idle edge far from sof: ignored
    send_event(1'b0, 16'd300, 1'b1);     // sof width at level 1: ignored
    send_event(1'b0, 16'd255, 1'b0);     // on the window edge: no match
    send_event(1'b0, 16'd256, 1'b0);     // just inside: frame start
    send_event(1'b0, 16'd67, 1'b0);      // short, level 0 -> 1
    send_event(1'b0, 16'd125, 1'b1);     // short, level 1 -> 0
    send_event(1'b0, 16'd163, 1'b1);     // long, level 1 -> 1
    send_event(1'b0, 16'd221, 1'b0);     // long, level 0 -> 0
    send_event(1'b0, 16'd96, 1'b0);
    send_event(1'b0, 16'd192, 1'b1);
    send_event(1'b0, 16'd96, 1'b1);
    send_event(1'b0, 16'd192, 1'b0);     // eighth bit: data byte
    send_event(1'b0, 16'd66, 1'b0);      // matches neither: symbol error
    send_event(1'b0, 16'hFFFF, 1'b1);    // idle, widest pulse: ignored
    send_event(1'b0, 16'd344, 1'b0);     // upper sof edge: frame start
    send_event(1'b0, 16'd96, 1'b0);
    send_event(1'b0, 16'd96, 1'b0);
    send_event(1'b1, 16'hFFFF, 1'b1);    // timeout drops the partial byte
    send_event(1'b1, 16'd0, 1'b0);       // timeout while idle again
    send_event(1'b0, 16'd300, 1'b0);
    send_event(1'b0, 16'hFFFF, 1'b0);    // widest pulse in a frame: error
    send_event(1'b0, 16'd300, 1'b0);
    send_event(1'b0, 16'd0, 1'b1);       // zero width in a frame: error
    random_traffic(45);

    // Random mid-range timing.
    drain_results();
    program_timing(16'($urandom_range(200, 400)), 16'($urandom_range(10, 60)),
                   16'($urandom_range(50, 120)), 16'($urandom_range(5, 30)),
                   16'($urandom_range(150, 260)), 16'($urandom_range(5, 40)));
    random_traffic(45);

    // Extremes: wide-open sof window, no short symbols, long only at full scale.
    drain_results();
    program_timing(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1);
    random_traffic(45);

    // Extremes: sof only at zero width, short takes almost anything, no long.
    drain_results();
    program_timing(16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    random_traffic(45);

    // Back to the nominal timing; fill the buffer once.
    drain_results();
    program_timing(vpw_pkg::SOF_WIDTH_RST, vpw_pkg::SOF_TOL_RST,
                   vpw_pkg::SHORT_WIDTH_RST, vpw_pkg::SHORT_TOL_RST,
                   vpw_pkg::LONG_WIDTH_RST, vpw_pkg::LONG_TOL_RST);
    send_frame(FRAME_LIMIT, 3, CLOSE_TIMEOUT);
    random_traffic(45);

    drain_results();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.flag($sformatf("%0d expected results never arrived",
                        sb.expected_results.size()));
    end
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("ERROR: timeout waiting for the receiver");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
